/* rtl/core/ssajm_pkg.sv */
package ssajm_pkg;

    // angles in 1/256 degree
    localparam int FULL_TURN = 92160;
    localparam int HALF_TURN = 46080;
    localparam int QUARTER   = 23040;

    localparam int CORDIC_ITERS = 16;
    localparam int CORDIC_X0    = 39797;

    // step gain 0.09 in Q16
    localparam int STEP_GAIN = 5898;

    localparam int MUL_W = 25;

    // CORDIC arctangent, 1/65536 degree
    function automatic logic signed [24:0] atan_val(input logic [3:0] i);
        case (i)
            4'd0:    return 25'sd2949120;
            4'd1:    return 25'sd1740967;
            4'd2:    return 25'sd919879;
            4'd3:    return 25'sd466945;
            4'd4:    return 25'sd234379;
            4'd5:    return 25'sd117304;
            4'd6:    return 25'sd58666;
            4'd7:    return 25'sd29335;
            4'd8:    return 25'sd14668;
            4'd9:    return 25'sd7334;
            4'd10:   return 25'sd3667;
            4'd11:   return 25'sd1833;
            4'd12:   return 25'sd917;
            4'd13:   return 25'sd458;
            4'd14:   return 25'sd229;
            4'd15:   return 25'sd115;
            default: return 25'sd0;
        endcase
    endfunction

endpackage

/* rtl/core/ssajm_mul.sv */
module ssajm_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ssajm_pkg::MUL_W-1:0]   i_a,
    input  logic signed [ssajm_pkg::MUL_W-1:0]   i_b,
    output logic                                 o_done,
    output logic signed [2*ssajm_pkg::MUL_W-1:0] o_p
);
    import ssajm_pkg::*;

    logic [MUL_W-1:0]   r_ma;
    logic [MUL_W-1:0]   r_mb;
    logic [2*MUL_W-1:0] r_acc;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [MUL_W:0]     sum;

    // one multiplier bit per cycle, accumulating into the upper half
    assign sum = {1'b0, r_acc[2*MUL_W-1:MUL_W]} + (r_mb[0] ? {1'b0, r_ma} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_ma   <= i_a[MUL_W-1] ? MUL_W'(-i_a) : i_a;
                r_mb   <= i_b[MUL_W-1] ? MUL_W'(-i_b) : i_b;
                r_neg  <= i_a[MUL_W-1] ^ i_b[MUL_W-1];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_acc  <= {sum, r_acc[MUL_W-1:1]};
                r_mb   <= r_mb >> 1;
                r_cnt  <= r_cnt + 5'd1;
                r_done <= 1'b0;
                if (r_cnt == 5'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_p    <= r_neg ? (~r_acc + 50'd1) : r_acc;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;

endmodule

/* rtl/core/ssajm_cordic.sv */
module ssajm_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_ang,
    input  logic               i_flip,
    output logic               o_done,
    output logic signed [19:0] o_sin,
    output logic signed [19:0] o_cos
);
    import ssajm_pkg::*;

    logic signed [19:0] r_x;
    logic signed [19:0] r_y;
    logic signed [24:0] r_z;
    logic [3:0]         r_i;
    logic               r_flip;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic signed [19:0] dx;
    logic signed [19:0] dy;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_x    <= 20'sd39797;
                r_y    <= '0;
                r_z    <= {i_ang[15], i_ang, 8'd0};
                r_flip <= i_flip;
                r_i    <= '0;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_val(r_i);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_val(r_i);
                end
                r_i    <= r_i + 4'd1;
                r_done <= 1'b0;
                if (r_i == 4'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_sin  <= r_y;
                o_cos  <= r_flip ? -r_x : r_x;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;

endmodule

/* rtl/core/smoothed_safe_arm_joint_move_top.sv */
// Smoothed, workspace-checked joint move for a base-rotating two-link arm. One target is
// accepted at a time (o_ready high only when idle). The first target after reset is applied
// at once and gives one result; later targets are approached in steps of 0.09 of the
// remaining difference until every joint is within one degree, at most MAX_STEPS steps,
// each step giving one result and the last one flagged with last_step. A target already
// reached gives no result. A step that passes the safety check runs three gain products,
// three 16-iteration CORDIC passes, five products for kinematics and the squared radius,
// and three servo products each followed by a restoring division. A blocked step has no
// servo products and a step with the check skipped has no CORDIC passes or kinematics
// products; each servo count that saturates skips its division, and the first target
// after reset has no gain products. One shared bit-serial multiplier forms every product,
// and a step waits before its result while the previous one is held for i_ready.
module smoothed_safe_arm_joint_move_top #(
    parameter int MAX_STEPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_base_target,
    input  logic [11:0] i_shoulder_target,
    input  logic [12:0] i_elbow_target,
    input  logic        i_skip_check,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_base_servo,
    output logic [9:0]  o_shoulder_servo,
    output logic [9:0]  o_elbow_servo,
    output logic        o_blocked,
    output logic        o_last_step
);
    import ssajm_pkg::*;

    localparam int CNT_W = $clog2(MAX_STEPS);
    localparam logic [49:0] R2_LIM = 50'd841813590016;  // 49 * 2^34

    typedef enum logic [4:0] {
        S_IDLE, S_ADV, S_ADV_W, S_CALC, S_COR, S_COR_W, S_KIN, S_MY, S_MY_W,
        S_MX, S_MX_W, S_SQ, S_SQ_W, S_CHK, S_SRV, S_SRV_W, S_DIV, S_EMIT
    } t_state;

    typedef struct packed {
        logic               flip;
        logic signed [15:0] r;
    } t_ang;

    t_state             r_state;
    logic               r_started;
    logic               r_first;
    logic               r_skip;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         r_j;
    logic [3:0]         r_bits;
    logic signed [17:0] r_held [3];
    logic signed [17:0] r_tgt  [3];
    logic signed [19:0] r_sin  [3];
    logic signed [19:0] r_cos  [3];
    logic               r_adv_neg;
    logic signed [24:0] r_r;
    logic signed [24:0] r_zk;
    logic signed [24:0] r_x;
    logic signed [24:0] r_y;
    logic [49:0]        r_sq;
    logic               r_blk;
    logic [9:0]         r_srv  [3];
    logic [33:0]        r_rem;
    logic [33:0]        r_dsh;
    logic [8:0]         r_q;

    logic                r_mul_go;
    logic signed [24:0]  r_mul_a;
    logic signed [24:0]  r_mul_b;
    logic                mul_done;
    logic signed [49:0]  mul_p;
    logic                r_cor_go;
    logic signed [15:0]  r_cor_ang;
    logic                r_cor_flip;
    logic                cor_done;
    logic signed [19:0]  cor_sin;
    logic signed [19:0]  cor_cos;

    logic               r_o_valid;
    logic [9:0]         r_o_base;
    logic [9:0]         r_o_sh;
    logic [9:0]         r_o_el;
    logic               r_o_blk;
    logic               r_o_last;

    function automatic logic far(input logic signed [17:0] h, input logic signed [17:0] t);
        logic signed [18:0] d;
        d = 19'(t) - 19'(h);
        return (d > 19'sd256) || (d < -19'sd256);
    endfunction

    function automatic t_ang reduce_ang(input logic signed [19:0] a);
        logic signed [19:0] v;
        t_ang o;
        v = a;
        if (v >= 20'(FULL_TURN)) v = 20'(v - FULL_TURN);
        else if (v <= -20'(FULL_TURN)) v = 20'(v + FULL_TURN);
        if (v >= 20'(HALF_TURN)) v = 20'(v - FULL_TURN);
        else if (v < -20'(HALF_TURN)) v = 20'(v + FULL_TURN);
        o.flip = 1'b0;
        if (v > 20'(QUARTER)) begin
            v = 20'(HALF_TURN - v);
            o.flip = 1'b1;
        end else if (v < -20'(QUARTER)) begin
            v = 20'(-HALF_TURN - v);
            o.flip = 1'b1;
        end
        o.r = v[15:0];
        return o;
    endfunction

    // 23*a + 32*b
    function automatic logic signed [24:0] lin_sum(input logic signed [19:0] a,
                                                   input logic signed [19:0] b);
        logic signed [24:0] ax;
        logic signed [24:0] bx;
        ax = 25'(a);
        bx = 25'(b);
        return (ax <<< 4) + (ax <<< 2) + (ax <<< 1) + ax + (bx <<< 5);
    endfunction

    // servo map: angle offset, output span, omin*den, den
    function automatic logic signed [19:0] srv_ofs(input logic [1:0] j);
        case (j)
            2'd0:    return 20'sd16640;
            2'd1:    return -20'sd8960;
            default: return 20'sd0;
        endcase
    endfunction

    function automatic logic signed [24:0] srv_slope(input logic [1:0] j);
        case (j)
            2'd0:    return 25'sd1023;
            2'd1:    return 25'sd620;
            default: return -25'sd930;
        endcase
    endfunction

    function automatic logic signed [31:0] srv_base(input logic [1:0] j);
        case (j)
            2'd0:    return 32'sd0;
            2'd1:    return 32'sd8537600;
            default: return 32'sd65664000;
        endcase
    endfunction

    function automatic logic [17:0] srv_den(input logic [1:0] j);
        case (j)
            2'd0:    return 18'd33280;
            2'd1:    return 18'd37120;
            default: return 18'd69120;
        endcase
    endfunction

    logic signed [17:0] in_tgt [3];
    logic               in_far;
    logic signed [18:0] adv_diff;
    logic [18:0]        adv_mag;
    logic [31:0]        adv_rnd;
    logic [14:0]        adv_d;
    logic signed [19:0] cor_sel;
    t_ang               cor_red;
    logic signed [31:0] srv_num;
    logic [33:0]        srv_n;
    logic [33:0]        srv_lim;
    logic               div_ge;
    logic               step_last;

    assign in_tgt[0] = {{2{i_base_target[11]}}, i_base_target, 4'd0};
    assign in_tgt[1] = {2'd0, i_shoulder_target, 4'd0};
    assign in_tgt[2] = {1'b0, i_elbow_target, 4'd0};
    assign in_far = far(r_held[0], in_tgt[0]) || far(r_held[1], in_tgt[1])
                 || far(r_held[2], in_tgt[2]);

    assign adv_diff = 19'(r_tgt[r_j]) - 19'(r_held[r_j]);
    assign adv_mag  = adv_diff[18] ? 19'(-adv_diff) : adv_diff;
    assign adv_rnd  = mul_p[31:0] + 32'd32768;
    assign adv_d    = adv_rnd[30:16];

    always_comb begin
        case (r_j)
            2'd0:    cor_sel = 20'(r_held[1]);
            2'd1:    cor_sel = 20'(r_held[2]) - 20'(HALF_TURN) + 20'(r_held[1]);
            default: cor_sel = 20'(r_held[0]);
        endcase
    end
    assign cor_red = reduce_ang(cor_sel);

    assign srv_num = srv_base(r_j) + $signed(mul_p[31:0]);
    assign srv_n   = 34'({srv_num, 1'b0}) + 34'(srv_den(r_j));
    assign srv_lim = 34'(srv_den(r_j)) << 11;
    assign div_ge  = r_rem >= r_dsh;

    assign step_last = r_first || (r_cnt == CNT_W'(MAX_STEPS - 1))
                    || !(far(r_held[0], r_tgt[0]) || far(r_held[1], r_tgt[1])
                         || far(r_held[2], r_tgt[2]));

    ssajm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    ssajm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_go),
        .i_ang   (r_cor_ang),
        .i_flip  (r_cor_flip),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_first   <= 1'b0;
            r_cnt     <= '0;
            r_j       <= '0;
            r_mul_go  <= 1'b0;
            r_cor_go  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // S_EMIT refills the output register itself
            if (r_o_valid && i_ready && r_state != S_EMIT) r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int k = 0; k < 3; k++) r_tgt[k] <= in_tgt[k];
                        r_skip <= i_skip_check;
                        r_cnt  <= '0;
                        r_j    <= '0;
                        if (!r_started) begin
                            for (int k = 0; k < 3; k++) r_held[k] <= in_tgt[k];
                            r_started <= 1'b1;
                            r_first   <= 1'b1;
                            r_state   <= S_CALC;
                        end else begin
                            r_first <= 1'b0;
                            if (in_far) r_state <= S_ADV;
                        end
                    end
                end
                S_ADV: begin
                    r_mul_a   <= 25'(adv_mag);
                    r_mul_b   <= 25'(STEP_GAIN);
                    r_adv_neg <= adv_diff[18];
                    r_mul_go  <= 1'b1;
                    r_state   <= S_ADV_W;
                end
                S_ADV_W: begin
                    r_mul_go <= 1'b0;
                    if (mul_done) begin
                        r_held[r_j] <= r_adv_neg ? r_held[r_j] - 18'(adv_d)
                                                 : r_held[r_j] + 18'(adv_d);
                        if (r_j == 2'd2) begin
                            r_j     <= '0;
                            r_state <= S_CALC;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_ADV;
                        end
                    end
                end
                S_CALC: begin
                    r_j     <= '0;
                    r_blk   <= 1'b0;
                    r_state <= r_skip ? S_SRV : S_COR;
                end
                S_COR: begin
                    r_cor_ang  <= cor_red.r;
                    r_cor_flip <= cor_red.flip;
                    r_cor_go   <= 1'b1;
                    r_state    <= S_COR_W;
                end
                S_COR_W: begin
                    r_cor_go <= 1'b0;
                    if (cor_done) begin
                        r_sin[r_j] <= cor_sin;
                        r_cos[r_j] <= cor_cos;
                        if (r_j == 2'd2) begin
                            r_state <= S_KIN;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_COR;
                        end
                    end
                end
                S_KIN: begin
                    r_r     <= lin_sum(r_cos[0], r_cos[1]);
                    r_zk    <= lin_sum(r_sin[0], r_sin[1]);
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_mul_a  <= r_r;
                    r_mul_b  <= 25'(r_cos[2]);
                    r_mul_go <= 1'b1;
                    r_state  <= S_MY_W;
                end
                S_MY_W: begin
                    r_mul_go <= 1'b0;
                    if (mul_done) begin
                        r_y     <= mul_p[40:16];
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_mul_a  <= -r_r;
                    r_mul_b  <= 25'(r_sin[2]);
                    r_mul_go <= 1'b1;
                    r_state  <= S_MX_W;
                end
                S_MX_W: begin
                    r_mul_go <= 1'b0;
                    if (mul_done) begin
                        r_x     <= mul_p[40:16];
                        r_sq    <= '0;
                        r_j     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    case (r_j)
                        2'd0: begin
                            r_mul_a <= r_x;
                            r_mul_b <= r_x;
                        end
                        2'd1: begin
                            r_mul_a <= r_y;
                            r_mul_b <= r_y;
                        end
                        default: begin
                            r_mul_a <= r_zk + 25'sd655360;
                            r_mul_b <= r_zk + 25'sd655360;
                        end
                    endcase
                    r_mul_go <= 1'b1;
                    r_state  <= S_SQ_W;
                end
                S_SQ_W: begin
                    r_mul_go <= 1'b0;
                    if (mul_done) begin
                        r_sq <= r_sq + mul_p;
                        if (r_j == 2'd2) begin
                            r_state <= S_CHK;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_CHK: begin
                    r_j <= '0;
                    if (r_sq < R2_LIM || r_zk < -25'sd655360 || r_zk > 25'sd3145728
                        || r_y < -25'sd131072) begin
                        r_blk <= 1'b1;
                        for (int k = 0; k < 3; k++) r_srv[k] <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SRV;
                    end
                end
                S_SRV: begin
                    r_mul_a  <= 25'(20'(r_held[r_j]) + srv_ofs(r_j));
                    r_mul_b  <= srv_slope(r_j);
                    r_mul_go <= 1'b1;
                    r_state  <= S_SRV_W;
                end
                S_SRV_W: begin
                    r_mul_go <= 1'b0;
                    if (mul_done) begin
                        if (srv_num[31] || srv_n >= srv_lim) begin
                            // negative rounds to zero, at or above full scale saturates
                            r_srv[r_j] <= srv_num[31] ? 10'd0 : 10'd1023;
                            if (r_j == 2'd2) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_j     <= r_j + 2'd1;
                                r_state <= S_SRV;
                            end
                        end else begin
                            r_rem   <= srv_n;
                            r_dsh   <= 34'(srv_den(r_j)) << 10;
                            r_bits  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_ge) r_rem <= r_rem - r_dsh;
                    r_dsh  <= r_dsh >> 1;
                    r_q    <= {r_q[7:0], div_ge};
                    r_bits <= r_bits + 4'd1;
                    if (r_bits == 4'd9) begin
                        r_srv[r_j] <= {r_q, div_ge};
                        if (r_j == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_SRV;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_base  <= r_srv[0];
                        r_o_sh    <= r_srv[1];
                        r_o_el    <= r_srv[2];
                        r_o_blk   <= r_blk;
                        r_o_last  <= step_last;
                        r_j       <= '0;
                        if (step_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_state <= S_ADV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_base_servo     = r_o_base;
    assign o_shoulder_servo = r_o_sh;
    assign o_elbow_servo    = r_o_el;
    assign o_blocked        = r_o_blk;
    assign o_last_step      = r_o_last;

    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_blocked) |->
            (o_base_servo == 10'd0 && o_shoulder_servo == 10'd0 && o_elbow_servo == 10'd0))
        else $error("blocked result with nonzero servo count");

    a_first_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !r_started) |=> !o_ready)
        else $error("first target produced no step");

    a_adv_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) |-> r_started)
        else $error("stepping before any target");

endmodule
